// ===== sv/efq_pkg.sv =====
// Shared types and constants for the edge flip quality test.
package efq_pkg;

  // Field widths.
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int RAD_W   = 64;
  localparam int LEN_W   = 31;
  localparam int RAT_W   = 32;
  localparam int DIV_W   = 128;

  localparam int NUM_PTS   = 4;
  localparam int NUM_EDGES = 6;
  localparam int NUM_TRI   = 4;
  localparam int NUM_AXES  = 3;

  // Floor division by three: a bias that is a multiple of three makes the sum
  // non-negative, and a reciprocal multiply with a shift does the division.
  localparam int          DIV3_OFS   = 50331648;    // three times 2^24
  localparam logic [25:0] DIV3_MUL   = 26'd44739243; // ceil(2^27 / 3)
  localparam int          DIV3_SHIFT = 27;

  // Point codes.
  typedef logic [1:0] pt_idx_t;
  localparam pt_idx_t PT_S  = 2'd0;
  localparam pt_idx_t PT_E  = 2'd1;
  localparam pt_idx_t PT_C1 = 2'd2;
  localparam pt_idx_t PT_C2 = 2'd3;

  // The six distinct edges: S-E, S-C1, E-C1, S-C2, E-C2, C1-C2.
  typedef logic [2:0] edge_idx_t;
  localparam pt_idx_t EDGE_P [NUM_EDGES] = '{PT_S, PT_S, PT_E, PT_S, PT_E, PT_C1};
  localparam pt_idx_t EDGE_Q [NUM_EDGES] = '{PT_E, PT_C1, PT_C1, PT_C2, PT_C2, PT_C2};

  // Edges of each candidate triangle.
  localparam edge_idx_t TRI_EDGE [NUM_TRI][3] = '{
    '{3'd2, 3'd0, 3'd1},
    '{3'd3, 3'd0, 3'd4},
    '{3'd5, 3'd3, 3'd1},
    '{3'd4, 3'd5, 3'd2}
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] edge_start_x;
    logic signed [COORD_W-1:0] edge_start_y;
    logic signed [COORD_W-1:0] edge_start_z;
    logic signed [COORD_W-1:0] edge_end_x;
    logic signed [COORD_W-1:0] edge_end_y;
    logic signed [COORD_W-1:0] edge_end_z;
    logic signed [COORD_W-1:0] own_third_x;
    logic signed [COORD_W-1:0] own_third_y;
    logic signed [COORD_W-1:0] own_third_z;
    logic signed [COORD_W-1:0] far_x;
    logic signed [COORD_W-1:0] far_y;
    logic signed [COORD_W-1:0] far_z;
  } efq_in_t;

  typedef struct packed {
    logic [1:0]       worst_index;
    logic             do_flip;
    logic [RAT_W-1:0] worst_ratio;
  } efq_out_t;

endpackage

// ===== sv/efq_front.sv =====
// Front pipeline: centroids, edge vectors and squared edge lengths.
module efq_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  efq_pkg::efq_in_t in_data,
  output logic             out_vld,
  output logic [63:0]      d2 [6]
);
  import efq_pkg::*;

  logic signed [COORD_W-1:0] s_c [NUM_AXES];
  logic signed [COORD_W-1:0] e_c [NUM_AXES];
  logic signed [COORD_W-1:0] t_c [NUM_AXES];
  logic signed [COORD_W-1:0] f_c [NUM_AXES];

  logic signed [COORD_W-1:0] s1_r [NUM_AXES];
  logic signed [COORD_W-1:0] e1_r [NUM_AXES];
  logic [26:0]               u1_r [NUM_AXES];
  logic [26:0]               u2_r [NUM_AXES];
  logic signed [COORD_W-1:0] s2_r [NUM_AXES];
  logic signed [COORD_W-1:0] e2_r [NUM_AXES];
  logic [51:0]               m1_r [NUM_AXES];
  logic [51:0]               m2_r [NUM_AXES];
  logic signed [COORD_W-1:0] pts_r [NUM_PTS][NUM_AXES];
  logic signed [DIFF_W-1:0]  diff_r [NUM_EDGES][NUM_AXES];
  logic signed [SQ_W-1:0]    sq_nxt [NUM_EDGES][NUM_AXES];
  logic [SQ_W-1:0]           sq_r [NUM_EDGES][NUM_AXES];
  logic [RAD_W-1:0]          d2_r [NUM_EDGES];
  logic [5:0]                vld_r;

  // Unpack the coordinates per axis.
  always_comb begin
    s_c[0] = in_data.edge_start_x; s_c[1] = in_data.edge_start_y;
    s_c[2] = in_data.edge_start_z;
    e_c[0] = in_data.edge_end_x;   e_c[1] = in_data.edge_end_y;
    e_c[2] = in_data.edge_end_z;
    t_c[0] = in_data.own_third_x;  t_c[1] = in_data.own_third_y;
    t_c[2] = in_data.own_third_z;
    f_c[0] = in_data.far_x;        f_c[1] = in_data.far_y;
    f_c[2] = in_data.far_z;
  end

  // Biased vertex sums, their reciprocal products and the centroids.
  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s1_r[a] <= s_c[a];
      e1_r[a] <= e_c[a];
      u1_r[a] <= 27'(s_c[a]) + 27'(e_c[a]) + 27'(t_c[a]) + 27'(DIV3_OFS);
      u2_r[a] <= 27'(s_c[a]) + 27'(e_c[a]) + 27'(f_c[a]) + 27'(DIV3_OFS);
      s2_r[a] <= s1_r[a];
      e2_r[a] <= e1_r[a];
      m1_r[a] <= 52'(u1_r[a]) * 52'(DIV3_MUL);
      m2_r[a] <= 52'(u2_r[a]) * 52'(DIV3_MUL);
      // Removing the 2^24 bias leaves the low 24 bits of the quotient untouched.
      pts_r[PT_S][a]  <= s2_r[a];
      pts_r[PT_E][a]  <= e2_r[a];
      pts_r[PT_C1][a] <= signed'(m1_r[a][DIV3_SHIFT+COORD_W-1:DIV3_SHIFT]);
      pts_r[PT_C2][a] <= signed'(m2_r[a][DIV3_SHIFT+COORD_W-1:DIV3_SHIFT]);
    end
  end

  // Edge vectors and their squared components.
  always_comb begin
    for (int j = 0; j < NUM_EDGES; j++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        sq_nxt[j][a] = diff_r[j][a] * diff_r[j][a];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_EDGES; j++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        diff_r[j][a] <= DIFF_W'(pts_r[EDGE_P[j]][a]) - DIFF_W'(pts_r[EDGE_Q[j]][a]);
        sq_r[j][a]   <= unsigned'(sq_nxt[j][a]);
      end
      // Squared length scaled by 4096, so the root comes out in units of 2^-22.
      d2_r[j] <= {52'(sq_r[j][0]) + 52'(sq_r[j][1]) + 52'(sq_r[j][2]), 12'b0};
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  assign out_vld = vld_r[5];
  assign d2      = d2_r;

endmodule

// ===== sv/efq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module efq_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] rad,
  output logic        out_vld,
  output logic [30:0] root
);
  import efq_pkg::*;

  localparam int STEPS = RAD_W / 2;

  logic [RAD_W-1:0] rem_r [STEPS];
  logic [RAD_W-1:0] res_r [STEPS];
  logic             vld_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << (RAD_W - 2 - 2 * i);
    logic [RAD_W-1:0] rem_in;
    logic [RAD_W-1:0] res_in;
    logic [RAD_W-1:0] trial;
    logic [RAD_W-1:0] rem_nxt;
    logic [RAD_W-1:0] res_nxt;
    logic             vld_in;

    if (i == 0) begin : g_first
      assign rem_in = rad;
      assign res_in = '0;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign res_in = res_r[i-1];
      assign vld_in = vld_r[i-1];
    end

    // One restoring step: try to take the next root bit.
    always_comb begin
      trial = res_in + STEP_BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + STEP_BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      res_r[i] <= res_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end
  end

  assign out_vld = vld_r[STEPS-1];
  assign root    = res_r[STEPS-1][LEN_W-1:0];

endmodule

// ===== sv/efq_ratio.sv =====
// Radius ratio of one triangle from its edge lengths, with a pipelined divider.
module efq_ratio (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [30:0] len_a,
  input  logic [30:0] len_b,
  input  logic [30:0] len_c,
  output logic        out_vld,
  output logic [31:0] ratio
);
  import efq_pkg::*;

  logic signed [LEN_W+1:0] p_s, q_s, r_s;
  logic [LEN_W-1:0] a1_r, b1_r, c1_r, c2_r;
  logic [31:0]      p1_r, q1_r, r1_r, r2_r;
  logic [61:0]      ab_r, abl_r, abh_r;
  logic [63:0]      pq_r, pql_r, pqh_r;
  logic [DIV_W-1:0] num_r, den_r, num5_r, den5_r;
  logic             deg1_r, deg2_r, deg3_r, deg4_r, sat5_r;
  logic [4:0]       vld_r;

  logic [DIV_W-1:0] rem_r  [RAT_W];
  logic [DIV_W-1:0] dvs_r  [RAT_W];
  logic [RAT_W-1:0] quo_r  [RAT_W];
  logic             flag_r [RAT_W];
  logic             dvld_r [RAT_W];

  // Semiperimeter differences, doubled; a triangle with any of them not positive
  // is degenerate.
  always_comb begin
    p_s = $signed({2'b0, len_b}) + $signed({2'b0, len_c}) - $signed({2'b0, len_a});
    q_s = $signed({2'b0, len_a}) + $signed({2'b0, len_c}) - $signed({2'b0, len_b});
    r_s = $signed({2'b0, len_a}) + $signed({2'b0, len_b}) - $signed({2'b0, len_c});
  end

  // Products are split into halves so no multiplier exceeds 32 by 32 bits.
  always_ff @(posedge clk) begin
    a1_r   <= len_a;
    b1_r   <= len_b;
    c1_r   <= len_c;
    p1_r   <= p_s[31:0];
    q1_r   <= q_s[31:0];
    r1_r   <= r_s[31:0];
    deg1_r <= (p_s <= 0) || (q_s <= 0) || (r_s <= 0);

    ab_r   <= 62'(a1_r) * 62'(b1_r);
    pq_r   <= 64'(p1_r) * 64'(q1_r);
    c2_r   <= c1_r;
    r2_r   <= r1_r;
    deg2_r <= deg1_r;

    abl_r  <= 62'(ab_r[30:0]) * 62'(c2_r);
    abh_r  <= 62'(ab_r[61:31]) * 62'(c2_r);
    pql_r  <= 64'(pq_r[31:0]) * 64'(r2_r);
    pqh_r  <= 64'(pq_r[63:32]) * 64'(r2_r);
    deg3_r <= deg2_r;

    // Numerator 2abc scaled to Q16.16, denominator PQR.
    num_r  <= ((DIV_W'(abh_r) << 31) + DIV_W'(abl_r)) << 17;
    den_r  <= (DIV_W'(pqh_r) << 32) + DIV_W'(pql_r);
    deg4_r <= deg3_r;

    // A quotient of 2^32 or more saturates.
    num5_r <= num_r;
    den5_r <= den_r;
    sat5_r <= deg4_r || (num_r >= (den_r << 32));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  // Restoring division, one quotient bit per stage from the top bit down.
  for (genvar i = 0; i < RAT_W; i++) begin : g_div
    localparam int K = RAT_W - 1 - i;
    logic [DIV_W-1:0] rem_in, dvs_in, trial;
    logic [RAT_W-1:0] quo_in;
    logic             flag_in, vld_in;

    if (i == 0) begin : g_first
      assign rem_in  = num5_r;
      assign dvs_in  = den5_r;
      assign quo_in  = '0;
      assign flag_in = sat5_r;
      assign vld_in  = vld_r[4];
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign dvs_in  = dvs_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign flag_in = flag_r[i-1];
      assign vld_in  = dvld_r[i-1];
    end

    assign trial = dvs_in << K;

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_r[i] <= rem_in - trial;
        quo_r[i] <= quo_in | (RAT_W'(1) << K);
      end else begin
        rem_r[i] <= rem_in;
        quo_r[i] <= quo_in;
      end
      dvs_r[i]  <= dvs_in;
      flag_r[i] <= flag_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[i] <= 1'b0;
      end else begin
        dvld_r[i] <= vld_in;
      end
    end
  end

  assign out_vld = dvld_r[RAT_W-1];
  assign ratio   = flag_r[RAT_W-1] ? '1 : quo_r[RAT_W-1];

endmodule

// ===== sv/edge_flip_quality_test.sv =====
// Top level of the edge flip quality test: front, six roots, four ratios, selection.
//
// One transaction is taken in every cycle in which start is high; busy stays low,
// so items may follow each other back to back. Each result appears on out_data
// for one cycle, marked by out_valid, in the order the transactions came in. The
// path runs through six front stages, the 32-stage square root pipeline, five
// product stages, the 32-stage quotient pipeline and two selection stages in
// series; the receiver cannot hold results off, and none are needed: there is no
// stall.
module edge_flip_quality_test (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  efq_pkg::efq_in_t  in_data,
  output logic              out_valid,
  output efq_pkg::efq_out_t out_data
);
  import efq_pkg::*;

  localparam int LATENCY = 77;

  logic             front_vld;
  logic [RAD_W-1:0] d2 [NUM_EDGES];
  logic             len_vld [NUM_EDGES];
  logic [LEN_W-1:0] len [NUM_EDGES];
  logic             rat_vld [NUM_TRI];
  logic [RAT_W-1:0] rat [NUM_TRI];

  logic [RAT_W-1:0] w01_r, w23_r;
  logic             i01_r, i23_r;
  logic             sel_vld_r;
  efq_out_t         out_nxt;
  efq_out_t         out_r;
  logic             out_vld_r;

  assign busy = 1'b0;

  efq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_data (in_data),
    .out_vld (front_vld),
    .d2      (d2)
  );

  // One root unit per distinct edge.
  for (genvar j = 0; j < NUM_EDGES; j++) begin : g_len
    efq_sqrt u_sqrt (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (front_vld),
      .rad     (d2[j]),
      .out_vld (len_vld[j]),
      .root    (len[j])
    );
  end

  // One ratio unit per candidate triangle.
  for (genvar t = 0; t < NUM_TRI; t++) begin : g_tri
    efq_ratio u_ratio (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (len_vld[0]),
      .len_a   (len[TRI_EDGE[t][0]]),
      .len_b   (len[TRI_EDGE[t][1]]),
      .len_c   (len[TRI_EDGE[t][2]]),
      .out_vld (rat_vld[t]),
      .ratio   (rat[t])
    );
  end

  // Pairwise maximum; the lower index keeps a tie.
  always_ff @(posedge clk) begin
    i01_r <= rat[1] > rat[0];
    w01_r <= (rat[1] > rat[0]) ? rat[1] : rat[0];
    i23_r <= rat[3] > rat[2];
    w23_r <= (rat[3] > rat[2]) ? rat[3] : rat[2];
  end

  // Final pick and the flip decision.
  always_comb begin
    if (w23_r > w01_r) begin
      out_nxt.worst_index = {1'b1, i23_r};
      out_nxt.worst_ratio = w23_r;
      out_nxt.do_flip     = 1'b0;
    end else begin
      out_nxt.worst_index = {1'b0, i01_r};
      out_nxt.worst_ratio = w01_r;
      out_nxt.do_flip     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      sel_vld_r <= rat_vld[0];
      out_vld_r <= sel_vld_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Every accepted transaction yields its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after a transaction");

  // The four ratio lanes stay in lockstep.
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (rat_vld[0] == rat_vld[1]) && (rat_vld[0] == rat_vld[2]) &&
    (rat_vld[0] == rat_vld[3]))
    else $error("ratio lanes out of step");

  // A later candidate wins only with a ratio strictly above zero.
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.worst_index != 2'd0)) |-> (out_data.worst_ratio != '0))
    else $error("nonzero index with zero ratio");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the edge flip quality test block.
`timescale 1ns / 100ps

module tb;
  import efq_pkg::*;

  typedef longint vec3_t [3];

  localparam int  LATENCY   = 77;
  localparam int  MAX_CYCLE = 400000;
  localparam logic [31:0] RATIO_FULL = 32'hFFFF_FFFF;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  efq_in_t  in_data;
  logic     out_valid;
  efq_out_t out_data;

  efq_out_t verdicts_due [$];
  int       errors = 0;
  int       cycle = 0;
  bit       steady_feed;

  edge_flip_quality_test dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Floor of a sum divided by three.
  function automatic longint third_floor(longint s);
    return (s + 3 * 64'sd67108864) / 3 - 64'sd67108864;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Side length in units of 2^-22.
  function automatic logic [63:0] side_len(vec3_t p, vec3_t q);
    logic [63:0] d2;
    longint d;
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      d = p[i] - q[i];
      d2 = d2 + 64'(d * d);
    end
    return root_floor(d2 << 12);
  endfunction

  // Circumradius over inradius, Q16.16, saturating.
  function automatic logic [31:0] shape_ratio(vec3_t u, vec3_t v, vec3_t w);
    logic [63:0]  a, b, c;
    longint       p, q, r;
    logic [127:0] num, den;
    a = side_len(v, w);
    b = side_len(u, w);
    c = side_len(u, v);
    p = longint'(b + c) - longint'(a);
    q = longint'(a + c) - longint'(b);
    r = longint'(a + b) - longint'(c);
    if (p <= 0 || q <= 0 || r <= 0) return RATIO_FULL;
    num = (128'(a) * 128'(b) * 128'(c)) << 17;
    den = 128'(p) * 128'(q) * 128'(r);
    if (num >= (den << 32)) return RATIO_FULL;
    return 32'(num / den);
  endfunction

  function automatic efq_out_t flip_verdict(efq_in_t x);
    vec3_t s, e, t, f, c1, c2;
    logic [31:0] best, rat;
    logic [1:0]  worst;
    efq_out_t    res;
    s = '{longint'(x.edge_start_x), longint'(x.edge_start_y), longint'(x.edge_start_z)};
    e = '{longint'(x.edge_end_x), longint'(x.edge_end_y), longint'(x.edge_end_z)};
    t = '{longint'(x.own_third_x), longint'(x.own_third_y), longint'(x.own_third_z)};
    f = '{longint'(x.far_x), longint'(x.far_y), longint'(x.far_z)};
    best = 0;
    worst = 0;
    for (int i = 0; i < 3; i++) begin
      c1[i] = third_floor(s[i] + e[i] + t[i]);
      c2[i] = third_floor(s[i] + e[i] + f[i]);
    end
    // Candidates in order; only a strictly larger ratio replaces the best.
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: rat = shape_ratio(s, c1, e);
        1: rat = shape_ratio(e, c2, s);
        2: rat = shape_ratio(s, c1, c2);
        default: rat = shape_ratio(c1, e, c2);
      endcase
      if (rat > best) begin
        best = rat;
        worst = 2'(k);
      end
    end
    res.worst_index = worst;
    res.do_flip = (worst <= 2'd1);
    res.worst_ratio = best;
    return res;
  endfunction

  // Send one transaction, with random idle cycles ahead of it unless steady_feed is set.
  task automatic send_quad(efq_in_t x);
    while (!steady_feed && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (busy);
    verdicts_due = {verdicts_due, flip_verdict(x)};
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    efq_out_t want;
    if (rst_n && out_valid) begin
      if (verdicts_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = verdicts_due.pop_front();
        if (out_data.worst_index !== want.worst_index || out_data.do_flip !== want.do_flip
            || out_data.worst_ratio !== want.worst_ratio) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected idx %0d flip %0d ratio %h, got idx %0d flip %0d ratio %h",
                     want.worst_index, want.do_flip, want.worst_ratio,
                     out_data.worst_index, out_data.do_flip, out_data.worst_ratio);
        end
      end
    end
  end

  function automatic logic signed [23:0] near(int base, int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return 24'(v);
  endfunction

  function automatic efq_in_t quad_from(int v [12]);
    efq_in_t x;
    x = {24'(v[0]), 24'(v[1]), 24'(v[2]), 24'(v[3]), 24'(v[4]), 24'(v[5]),
         24'(v[6]), 24'(v[7]), 24'(v[8]), 24'(v[9]), 24'(v[10]), 24'(v[11])};
    return x;
  endfunction

  // Coincident and collinear points give degenerate triangles.
  task automatic test_degenerate();
    send_quad('0);
    send_quad(quad_from('{0, 0, 0, 65536, 0, 0, 131072, 0, 0, -65536, 0, 0}));
    send_quad(quad_from('{100, 100, 100, 100, 100, 100, 100, 100, 100, 5, 5, 5}));
    send_quad(quad_from('{0, 0, 0, 65536, 65536, 0, 0, 65536, 0, 65536, 65536, 0}));
  endtask

  // Field extremes, including the sign bit of every coordinate.
  task automatic test_extremes();
    send_quad({12{24'h7FFFFF}});
    send_quad({12{24'h800000}});
    send_quad({{3{24'h800000}}, {3{24'h7FFFFF}}, {3{24'h800000}}, {3{24'h7FFFFF}}});
    send_quad({{3{24'h7FFFFF}}, {3{24'h800000}}, {3{24'h7FFFFF}}, {3{24'h800000}}});
    send_quad(quad_from('{-8388608, 0, 0, 8388607, 0, 0, 0, 8388607, 0, 0, -8388608, 0}));
    send_quad(quad_from('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1}));
    send_quad(quad_from('{-1, -1, -1, 1, 1, 1, -1, 1, 0, 1, -1, 0}));
  endtask

  // Well-shaped and slivered pairs, steering the worst candidate around.
  task automatic test_shapes();
    send_quad(quad_from('{0, 0, 0, 65536, 0, 0, 32768, 56756, 0, 32768, -56756, 0}));
    send_quad(quad_from('{0, 0, 0, 655360, 0, 0, 327680, 6553, 0, 327680, -655360, 0}));
    send_quad(quad_from('{0, 0, 0, 655360, 0, 0, 327680, 655360, 0, 327680, -6553, 0}));
    send_quad(quad_from('{0, 0, 0, 65536, 0, 0, -300000, 4000, 0, 400000, -5000, 0}));
    send_quad(quad_from('{0, 0, 0, 65536, 0, 0, 400000, 5000, 9, -300000, -4000, 7}));
    send_quad(quad_from('{0, 0, 0, 1000, 0, 0, 0, 1000000, 0, 0, -1000000, 0}));
    send_quad(quad_from('{0, 0, 0, 0, 0, 65536, 50000, 0, 30000, -50000, 1, 30000}));
  endtask

  // Mesh-like edges: four points clustered near one spot.
  task automatic test_random_mesh(int count);
    int v [12];
    int cx, cy, cz, span;
    for (int n = 0; n < count; n++) begin
      cx = int'($urandom_range(0, 16000000)) - 8000000;
      cy = int'($urandom_range(0, 16000000)) - 8000000;
      cz = int'($urandom_range(0, 16000000)) - 8000000;
      span = 1 << $urandom_range(2, 22);
      for (int k = 0; k < 4; k++) begin
        v[3 * k]     = near(cx, span);
        v[3 * k + 1] = near(cy, span);
        v[3 * k + 2] = ($urandom_range(0, 3) == 0) ? cz : near(cz, span / 8 + 1);
      end
      // Now and then make a point repeat or lie on the edge.
      if ($urandom_range(0, 19) == 0) begin
        v[6] = v[0]; v[7] = v[1]; v[8] = v[2];
      end
      if ($urandom_range(0, 19) == 0) begin
        v[9] = (v[0] + v[3]) / 2; v[10] = (v[1] + v[4]) / 2; v[11] = (v[2] + v[5]) / 2;
      end
      send_quad(quad_from(v));
    end
  endtask

  // Unstructured coordinates over the whole range.
  task automatic test_random_noise(int count);
    efq_in_t x;
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 12; k++) x[24 * k +: 24] = 24'($urandom);
      send_quad(x);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    steady_feed = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_degenerate();
    test_extremes();
    test_shapes();
    test_random_mesh(500);
    steady_feed = 1'b1;
    test_random_mesh(300);
    steady_feed = 1'b0;
    test_random_noise(300);
    test_random_mesh(180);
    start <= 1'b0;

    // Drain the pipeline.
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
